// File: src/message_frame_ring_buffer_top_macros.svh
// Assertion macros for the message frame ring buffer.
// Used by the top level; no other dependencies.
`ifndef MESSAGE_FRAME_RING_BUFFER_TOP_MACROS_SVH
`define MESSAGE_FRAME_RING_BUFFER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MFRB_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define MFRB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define MFRB_ASSERT_IMPL(name, clk, rst, ante, cons)
`define MFRB_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: src/mfrb_pkg.sv
// Shared constants, codes and controller/datapath interface structs
// for the message frame ring buffer. No dependencies.
`default_nettype none

package mfrb_pkg;

   localparam int NUM_MSGS    = 8;
   localparam int MSG_LEN     = 64;
   localparam int STORE_DEPTH = NUM_MSGS * MSG_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SLOT_W      = $clog2(NUM_MSGS);
   localparam int FILL_W      = $clog2(MSG_LEN);
   localparam int OCC_W       = $clog2(NUM_MSGS + 1);
   // slot difference with one spare bit for the modulo wrap
   localparam int DIFF_W      = SLOT_W + 1;

   localparam int OPCODE_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int OCC_FIELD_W = 4;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_USED_W  = BYTE_W + OCC_FIELD_W + 1;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [BYTE_W-1:0] END_CHAR_RESET = 8'd10;
   // register index is the word address bit
   localparam logic REG_END_CHAR = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_SEAL  = 2'd1,
      OP_POP   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED      = 3'd0,
      ST_SEALED      = 3'd1,
      ST_SEALED_FULL = 3'd2,
      ST_SEAL_EMPTY  = 3'd3,
      ST_POP_NONE    = 3'd4,
      ST_POP_BYTE    = 3'd5
   } status_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic term_wr;
      logic pop_rd;
      logic pop_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_term;
      logic start_pop;
      logic pop_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: src/mfrb_ctrl.sv
// Controller state machine for the message frame ring buffer.
// Depends on mfrb_pkg; drives commands into mfrb_dpath.
`default_nettype none

module mfrb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire mfrb_pkg::sts_type sts,
   output mfrb_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      S_CLEAR    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_TERM     = 5'b00100,
      S_POP_RD   = 5'b01000,
      S_POP_WAIT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_tready   = (state_ff == S_IDLE) && sts.out_free;
      cmd.accept   = req_tvalid && req_tready;
      cmd.clear_en = (state_ff == S_CLEAR);
      cmd.term_wr  = (state_ff == S_TERM);
      cmd.pop_rd   = (state_ff == S_POP_RD);
      cmd.pop_load = (state_ff == S_POP_WAIT) && sts.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd.accept && sts.need_term) begin
               state_in = S_TERM;
            end else if (cmd.accept && sts.start_pop) begin
               state_in = S_POP_RD;
            end
         end
         S_TERM: begin
            state_in = S_IDLE;
         end
         S_POP_RD: begin
            state_in = S_POP_WAIT;
         end
         S_POP_WAIT: begin
            if (sts.out_free) state_in = sts.pop_last ? S_IDLE : S_POP_RD;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/mfrb_dpath.sv
// Datapath of the message frame ring buffer: message store, slot and
// count registers, config register and result register. Depends on mfrb_pkg.
`default_nettype none

module mfrb_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mfrb_pkg::cmd_type                    cmd,
   output mfrb_pkg::sts_type                         sts,
   input  wire logic [mfrb_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic [mfrb_pkg::OPCODE_W-1:0]        req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [mfrb_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic [mfrb_pkg::STATUS_W-1:0]             rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [mfrb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [mfrb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mfrb_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                      csr_pready
);

   logic [mfrb_pkg::BYTE_W-1:0] store_mem [mfrb_pkg::STORE_DEPTH];

   logic [mfrb_pkg::ADDR_W-1:0]  clr_addr_ff;
   logic [mfrb_pkg::SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [mfrb_pkg::OCC_W-1:0]   occ_ff, occ_in;
   logic [mfrb_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [mfrb_pkg::BYTE_W-1:0]  end_char_ff;
   logic [mfrb_pkg::ADDR_W-1:0]  term_addr_ff, term_addr_in;
   logic [mfrb_pkg::ADDR_W-1:0]  pop_base_ff, pop_base_in;
   logic [mfrb_pkg::FILL_W-1:0]  pop_idx_ff, pop_idx_in;
   logic [mfrb_pkg::BYTE_W-1:0]  rd_data_ff;

   logic                          rsp_valid_ff;
   mfrb_pkg::status_type          rsp_status_ff;
   logic [mfrb_pkg::BYTE_W-1:0]   rsp_byte_ff;
   logic                          rsp_last_ff;
   logic [mfrb_pkg::OCC_FIELD_W-1:0] rsp_occ_ff;
   logic                          rsp_full_ff;

   mfrb_pkg::opcode_type          op;
   logic [mfrb_pkg::BYTE_W-1:0]   in_byte;
   logic                          in_seal_on_end;

   logic [mfrb_pkg::ADDR_W-1:0]   slot_base;
   logic [mfrb_pkg::FILL_W-1:0]   wr_pos;
   logic [mfrb_pkg::FILL_W-1:0]   new_fill;
   logic                          seal_hit;
   logic                          fill_nz;
   logic [mfrb_pkg::OCC_W-1:0]    occ_inc;
   logic [mfrb_pkg::SLOT_W-1:0]   slot_next;
   logic [mfrb_pkg::DIFF_W-1:0]   oldest_diff;
   logic [mfrb_pkg::SLOT_W-1:0]   oldest_slot;
   logic [mfrb_pkg::ADDR_W-1:0]   oldest_base;

   logic                          mem_we;
   logic [mfrb_pkg::ADDR_W-1:0]   mem_addr;
   logic [mfrb_pkg::BYTE_W-1:0]   mem_wdata;

   logic                          res_load;
   mfrb_pkg::status_type          res_status;
   logic [mfrb_pkg::BYTE_W-1:0]   res_byte;
   logic                          res_last;
   logic                          csr_wr;

   // request decode
   always_comb begin
      op             = mfrb_pkg::opcode_type'(req_tuser);
      in_byte        = req_tdata[mfrb_pkg::BYTE_W-1:0];
      in_seal_on_end = req_tdata[mfrb_pkg::BYTE_W];
   end

   always_comb begin
      slot_base = mfrb_pkg::ADDR_W'(write_slot_ff) * mfrb_pkg::ADDR_W'(mfrb_pkg::MSG_LEN);
      wr_pos    = (fill_ff < mfrb_pkg::FILL_W'(mfrb_pkg::MSG_LEN - 1)) ?
                  fill_ff : mfrb_pkg::FILL_W'(mfrb_pkg::MSG_LEN - 2);
      new_fill  = wr_pos + 1'b1;
      seal_hit  = (in_seal_on_end && (in_byte == end_char_ff)) ||
                  (new_fill == mfrb_pkg::FILL_W'(mfrb_pkg::MSG_LEN - 1));
      fill_nz   = (fill_ff != '0);
      occ_inc   = (occ_ff == mfrb_pkg::OCC_W'(mfrb_pkg::NUM_MSGS)) ? occ_ff : occ_ff + 1'b1;
      slot_next = (write_slot_ff == mfrb_pkg::SLOT_W'(mfrb_pkg::NUM_MSGS - 1)) ?
                  '0 : write_slot_ff + 1'b1;
      // oldest = (write_slot - occupied) mod NUM_MSGS, one compare and subtract
      oldest_diff = mfrb_pkg::DIFF_W'(write_slot_ff) +
                    mfrb_pkg::DIFF_W'(mfrb_pkg::NUM_MSGS) - mfrb_pkg::DIFF_W'(occ_ff);
      if (oldest_diff >= mfrb_pkg::DIFF_W'(mfrb_pkg::NUM_MSGS)) begin
         oldest_slot = mfrb_pkg::SLOT_W'(oldest_diff - mfrb_pkg::DIFF_W'(mfrb_pkg::NUM_MSGS));
      end else begin
         oldest_slot = mfrb_pkg::SLOT_W'(oldest_diff);
      end
      oldest_base = mfrb_pkg::ADDR_W'(oldest_slot) *
                    mfrb_pkg::ADDR_W'(mfrb_pkg::MSG_LEN);
   end

   always_comb begin
      sts.clear_last = (clr_addr_ff == mfrb_pkg::ADDR_W'(mfrb_pkg::STORE_DEPTH - 1));
      sts.need_term  = (op == mfrb_pkg::OP_WRITE) && seal_hit;
      sts.start_pop  = (op == mfrb_pkg::OP_POP) && (occ_ff != '0);
      sts.pop_last   = (pop_idx_ff == mfrb_pkg::FILL_W'(mfrb_pkg::MSG_LEN - 1));
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // next state of slot bookkeeping and the result to register
   always_comb begin
      write_slot_in = write_slot_ff;
      occ_in        = occ_ff;
      fill_in       = fill_ff;
      term_addr_in  = term_addr_ff;
      pop_base_in   = pop_base_ff;
      pop_idx_in    = pop_idx_ff;
      res_load      = 1'b0;
      res_status    = mfrb_pkg::ST_STORED;
      res_byte      = '0;
      res_last      = 1'b1;
      if (cmd.accept) begin
         case (op)
            mfrb_pkg::OP_WRITE: begin
               res_load = 1'b1;
               if (seal_hit) begin
                  fill_in       = '0;
                  write_slot_in = slot_next;
                  occ_in        = occ_inc;
                  term_addr_in  = slot_base + mfrb_pkg::ADDR_W'(new_fill);
                  res_status    = (occ_inc == mfrb_pkg::OCC_W'(mfrb_pkg::NUM_MSGS)) ?
                                  mfrb_pkg::ST_SEALED_FULL : mfrb_pkg::ST_SEALED;
               end else begin
                  fill_in = new_fill;
               end
            end
            mfrb_pkg::OP_SEAL: begin
               res_load = 1'b1;
               if (fill_nz) begin
                  fill_in       = '0;
                  write_slot_in = slot_next;
                  occ_in        = occ_inc;
                  res_status    = (occ_inc == mfrb_pkg::OCC_W'(mfrb_pkg::NUM_MSGS)) ?
                                  mfrb_pkg::ST_SEALED_FULL : mfrb_pkg::ST_SEALED;
               end else begin
                  res_status = mfrb_pkg::ST_SEAL_EMPTY;
               end
            end
            mfrb_pkg::OP_POP: begin
               if (occ_ff == '0) begin
                  res_load   = 1'b1;
                  res_status = mfrb_pkg::ST_POP_NONE;
               end else begin
                  occ_in      = occ_ff - 1'b1;
                  pop_base_in = oldest_base;
                  pop_idx_in  = '0;
               end
            end
            default: begin
               res_load = 1'b0;
            end
         endcase
      end else if (cmd.pop_load) begin
         res_load   = 1'b1;
         res_status = mfrb_pkg::ST_POP_BYTE;
         res_byte   = rd_data_ff;
         res_last   = sts.pop_last;
         pop_idx_in = pop_idx_ff + 1'b1;
      end
   end

   // single store port; pops read the old byte and clear it in the same cycle
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = pop_base_ff + mfrb_pkg::ADDR_W'(pop_idx_ff);
      mem_wdata = '0;
      if (cmd.clear_en) begin
         mem_we   = 1'b1;
         mem_addr = clr_addr_ff;
      end else if (cmd.accept && (op == mfrb_pkg::OP_WRITE)) begin
         mem_we    = 1'b1;
         mem_addr  = slot_base + mfrb_pkg::ADDR_W'(wr_pos);
         mem_wdata = in_byte;
      end else if (cmd.accept && (op == mfrb_pkg::OP_SEAL) && fill_nz) begin
         mem_we   = 1'b1;
         mem_addr = slot_base + mfrb_pkg::ADDR_W'(fill_ff);
      end else if (cmd.term_wr) begin
         mem_we   = 1'b1;
         mem_addr = term_addr_ff;
      end else if (cmd.pop_rd) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_addr] <= mem_wdata;
      if (cmd.pop_rd) rd_data_ff <= store_mem[mem_addr];
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[mfrb_pkg::CSR_ADDR_W-1] == mfrb_pkg::REG_END_CHAR);

   always_comb begin
      csr_pready = 1'b1;
      if (csr_paddr[mfrb_pkg::CSR_ADDR_W-1] == mfrb_pkg::REG_END_CHAR) begin
         csr_prdata = mfrb_pkg::CSR_DATA_W'(end_char_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         write_slot_ff <= '0;
         occ_ff        <= '0;
         fill_ff       <= '0;
         end_char_ff   <= mfrb_pkg::END_CHAR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_en) clr_addr_ff <= clr_addr_ff + 1'b1;
         write_slot_ff <= write_slot_in;
         occ_ff        <= occ_in;
         fill_ff       <= fill_in;
         if (csr_wr) end_char_ff <= csr_pwdata[mfrb_pkg::BYTE_W-1:0];
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      term_addr_ff <= term_addr_in;
      pop_base_ff  <= pop_base_in;
      pop_idx_ff   <= pop_idx_in;
      if (res_load) begin
         rsp_status_ff <= res_status;
         rsp_byte_ff   <= res_byte;
         rsp_last_ff   <= res_last;
         rsp_occ_ff    <= mfrb_pkg::OCC_FIELD_W'(occ_in);
         rsp_full_ff   <= (occ_in == mfrb_pkg::OCC_W'(mfrb_pkg::NUM_MSGS));
      end
   end

   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tlast  = rsp_last_ff;
      rsp_tuser  = rsp_status_ff;
      rsp_tdata  = {{(mfrb_pkg::RSP_TDATA_W - mfrb_pkg::RSP_USED_W){1'b0}},
                    rsp_full_ff, rsp_occ_ff, rsp_byte_ff};
   end

endmodule

`default_nettype wire

// File: src/message_frame_ring_buffer_top.sv
// Write or seal: result registered at the transfer; a write that seals writes
// the byte, then its terminator in S_TERM; other writes and seals skip S_TERM.
// Pop: each byte is read from the store (S_POP_RD), then loaded into the result
// register once it is free (S_POP_WAIT), MSG_LEN bytes per message.
// Reset clears the control state, then a clearing pass over all NUM_MSGS*MSG_LEN
// (512) store locations zeroes the store with req_tready low; csr writes are taken.
`default_nettype none
`include "message_frame_ring_buffer_top_macros.svh"

module message_frame_ring_buffer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] data_byte, [8] seal_on_end, [15:9] zero
   input  wire logic [mfrb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  wire logic [mfrb_pkg::OPCODE_W-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] out_byte, [11:8] occupied, [12] full_res, [15:13] zero
   output logic [mfrb_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [2:0] status
   output logic [mfrb_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                  rsp_tlast,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mfrb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [mfrb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mfrb_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   mfrb_pkg::cmd_type cmd;
   mfrb_pkg::sts_type sts;

   mfrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mfrb_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // no transfer while the store is being cleared
   `MFRB_ASSERT_IMPL(a_no_req_in_clear, clock, reset, cmd.clear_en, !req_tready)
   // a sealing byte write is followed by its terminator write
   `MFRB_ASSERT_NEXT(a_term_follows, clock, reset, cmd.accept && sts.need_term, cmd.term_wr)
   // popped bytes only load into a free result register
   `MFRB_ASSERT_IMPL(a_pop_load_free, clock, reset, cmd.pop_load, sts.out_free)

endmodule

`default_nettype wire
